@@ src/spg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spg_pkg: shared types and constants of the servo pattern generator
// Request codes, register indexes, pattern tables and intensity map constants.
// ----------------------------------------------------------------------------
package spg_pkg;

  localparam int unsigned PATTERN_LEN_DEF = 8;

  localparam logic [1:0] REQ_TICK      = 2'd0;
  localparam logic [1:0] REQ_SET_ANGLE = 2'd1;
  localparam logic [1:0] REQ_SWEEP     = 2'd2;
  localparam logic [1:0] REQ_ESTOP     = 2'd3;

  localparam logic [1:0] MODE_BOUNCE = 2'd0;
  localparam logic [1:0] MODE_RADAR  = 2'd1;
  localparam logic [1:0] MODE_ALERT  = 2'd2;

  localparam logic REG_SWEEP_MODE      = 1'b0;
  localparam logic REG_SWEEP_INTENSITY = 1'b1;

  localparam logic [1:0] MODE_RST      = MODE_BOUNCE;
  localparam logic [6:0] INTENSITY_RST = 7'd50;
  localparam logic [6:0] INTENSITY_MIN = 7'd1;
  localparam logic [6:0] INTENSITY_MAX = 7'd100;

  localparam logic [7:0] ANGLE_MAX    = 8'd180;
  localparam logic [7:0] ANGLE_CENTRE = 8'd90;
  localparam logic [7:0] ELAPSED_SAT  = 8'd255;

  // floor(x / 99) == (x * 662) >> 16 for every product used here
  localparam int unsigned RECIP_99    = 662;
  localparam int unsigned RECIP_SHIFT = 16;

  localparam logic [7:0]  BOUNCE_BASE = 8'd45;
  localparam logic [7:0]  RADAR_BASE  = 8'd120;
  localparam logic [7:0]  ALERT_BASE  = 8'd140;
  localparam logic [23:0] BOUNCE_COEF = 24'(40 * RECIP_99);
  localparam logic [23:0] RADAR_COEF  = 24'(102 * RECIP_99);
  localparam logic [23:0] ALERT_COEF  = 24'(115 * RECIP_99);
  localparam logic [3:0]  STEP_BASE   = 4'd2;
  localparam logic [19:0] STEP_COEF   = 20'(10 * RECIP_99);

  typedef struct packed {
    logic [7:0] angle;
    logic       dir_up;
    logic [7:0] elapsed;
    logic       sweep_on;
    logic       stop_on;
  } spg_state_t;

  typedef struct packed {
    logic [7:0] servo_angle;
    logic       sweep_active;
    logic       stop_active;
    logic       rejected;
    logic       moved;
  } spg_result_t;

  localparam spg_state_t STATE_RST = '{
    angle:    ANGLE_CENTRE,
    dir_up:   1'b1,
    elapsed:  ELAPSED_SAT,
    sweep_on: 1'b0,
    stop_on:  1'b0
  };

  function automatic logic [7:0] radar_angle(input logic [2:0] idx);
    logic [7:0] a;
    case (idx)
      3'd0:    a = 8'd25;
      3'd1:    a = 8'd55;
      3'd2:    a = 8'd90;
      3'd3:    a = 8'd125;
      3'd4:    a = 8'd155;
      3'd5:    a = 8'd125;
      3'd6:    a = 8'd90;
      3'd7:    a = 8'd55;
      default: a = 8'd90;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] alert_angle(input logic [2:0] idx);
    logic [7:0] a;
    case (idx)
      3'd0:    a = 8'd70;
      3'd1:    a = 8'd110;
      3'd2:    a = 8'd75;
      3'd3:    a = 8'd105;
      3'd4:    a = 8'd90;
      3'd5:    a = 8'd35;
      3'd6:    a = 8'd145;
      3'd7:    a = 8'd90;
      default: a = 8'd90;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

@@ src/spg_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spg_step: next-state logic of the servo pattern generator
// Applies one request to the current state and forms the result fields.
// ----------------------------------------------------------------------------
module spg_step #(
  parameter int unsigned PATTERN_LEN = spg_pkg::PATTERN_LEN_DEF,
  localparam int unsigned PW = (PATTERN_LEN > 2) ? $clog2(PATTERN_LEN) : 1
) (
  input  spg_pkg::spg_state_t  cur_i,
  input  logic [PW-1:0]        pos_i,
  input  logic [1:0]           mode_i,
  input  logic [6:0]           intensity_i,
  input  logic [1:0]           req_i,
  input  logic [7:0]           angle_i,
  input  logic                 en_i,
  output spg_pkg::spg_state_t  nxt_o,
  output logic [PW-1:0]        pos_o,
  output spg_pkg::spg_result_t res_o
);
  import spg_pkg::*;

  localparam logic [PW-1:0] POS_LAST = PW'(PATTERN_LEN - 1);

  logic [6:0]    int_clamped;
  logic [6:0]    k;
  logic [7:0]    base;
  logic [23:0]   coef;
  logic [23:0]   int_prod;
  logic [7:0]    interval;
  logic [19:0]   step_prod;
  logic [3:0]    step;
  logic [7:0]    elapsed_inc;
  logic [PW+2:0] pos_ext;
  logic [2:0]    tab_idx;
  logic [PW-1:0] pos_next;
  logic [8:0]    up_sum;
  logic [7:0]    down_diff;
  logic          rej;
  logic          mv;

  always_comb begin
    if (intensity_i < INTENSITY_MIN) begin
      int_clamped = INTENSITY_MIN;
    end else if (intensity_i > INTENSITY_MAX) begin
      int_clamped = INTENSITY_MAX;
    end else begin
      int_clamped = intensity_i;
    end
    k = int_clamped - 7'd1;
    case (mode_i)
      MODE_RADAR: begin
        base = RADAR_BASE;
        coef = RADAR_COEF;
      end
      MODE_ALERT: begin
        base = ALERT_BASE;
        coef = ALERT_COEF;
      end
      default: begin
        base = BOUNCE_BASE;
        coef = BOUNCE_COEF;
      end
    endcase
    int_prod  = 24'(k) * coef;
    interval  = base - int_prod[RECIP_SHIFT +: 8];
    step_prod = 20'(k) * STEP_COEF;
    step      = STEP_BASE + step_prod[RECIP_SHIFT +: 4];
  end

  assign elapsed_inc = (cur_i.elapsed == ELAPSED_SAT) ? ELAPSED_SAT : cur_i.elapsed + 8'd1;
  assign pos_ext     = {3'b000, pos_i};
  assign tab_idx     = pos_ext[2:0];
  assign pos_next    = (pos_i == POS_LAST) ? '0 : pos_i + PW'(1);
  assign up_sum      = {1'b0, cur_i.angle} + 9'(step);
  assign down_diff   = cur_i.angle - 8'(step);

  always_comb begin
    nxt_o = cur_i;
    pos_o = pos_i;
    rej   = 1'b0;
    mv    = 1'b0;
    case (req_i)
      REQ_TICK: begin
        nxt_o.elapsed = elapsed_inc;
        if (cur_i.sweep_on && (elapsed_inc >= interval)) begin
          nxt_o.elapsed = '0;
          mv            = 1'b1;
          case (mode_i)
            MODE_RADAR: begin
              nxt_o.angle = radar_angle(tab_idx);
              pos_o       = pos_next;
            end
            MODE_ALERT: begin
              nxt_o.angle = alert_angle(tab_idx);
              pos_o       = pos_next;
            end
            default: begin
              if (cur_i.dir_up) begin
                if (up_sum >= {1'b0, ANGLE_MAX}) begin
                  nxt_o.angle  = ANGLE_MAX;
                  nxt_o.dir_up = 1'b0;
                end else begin
                  nxt_o.angle = up_sum[7:0];
                end
              end else if (cur_i.angle <= 8'(step)) begin
                nxt_o.angle  = '0;
                nxt_o.dir_up = 1'b1;
              end else begin
                nxt_o.angle = down_diff;
              end
            end
          endcase
        end
      end
      REQ_SET_ANGLE: begin
        if (cur_i.stop_on || (angle_i > ANGLE_MAX)) begin
          rej = 1'b1;
        end else begin
          nxt_o.angle    = angle_i;
          nxt_o.sweep_on = 1'b0;
        end
      end
      REQ_SWEEP: begin
        if (cur_i.stop_on) begin
          rej = 1'b1;
        end else begin
          nxt_o.sweep_on = en_i;
          nxt_o.elapsed  = ELAPSED_SAT;
          pos_o          = '0;
          if (en_i) begin
            nxt_o.dir_up = 1'b1;
          end
        end
      end
      REQ_ESTOP: begin
        if (cur_i.stop_on != en_i) begin
          nxt_o.stop_on  = en_i;
          nxt_o.sweep_on = 1'b0;
          nxt_o.angle    = ANGLE_CENTRE;
          nxt_o.elapsed  = ELAPSED_SAT;
          pos_o          = '0;
        end
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

  assign res_o.servo_angle  = nxt_o.angle;
  assign res_o.sweep_active = nxt_o.sweep_on;
  assign res_o.stop_active  = nxt_o.stop_on;
  assign res_o.rejected     = rej;
  assign res_o.moved        = mv;

endmodule
`default_nettype wire

@@ src/servo_pattern_generator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// servo_pattern_generator_unit: servo sweep and pattern generator
// Input register, one pass of update logic, result register.
// ----------------------------------------------------------------------------
// Each result passes the input register and then the result register before its transfer.
// Throughput: 1 item per cycle while the result register is free; it stalls otherwise.
// The result register frees itself whenever m_axis_tready is high.
// Reset (rst_ni low, asynchronous): angle 90, direction up, pattern position 0,
// elapsed count saturated, sweep and stop off, mode 0, intensity 50, both
// pipeline registers empty.
module servo_pattern_generator_unit #(
  parameter int unsigned PATTERN_LEN = spg_pkg::PATTERN_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] angle_value, [8] enable_bit, rest zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] servo_angle, [8] sweep_active,
                                      // [9] stop_active, [10] rejected, [11] moved
);
  import spg_pkg::*;

  localparam int unsigned PW = (PATTERN_LEN > 2) ? $clog2(PATTERN_LEN) : 1;

  logic [1:0]  mode_q;
  logic [6:0]  intensity_q;

  logic        in_valid_q;
  logic [1:0]  in_req_q;
  logic [7:0]  in_angle_q;
  logic        in_en_q;

  spg_state_t  state_q, state_d;
  logic [PW-1:0] pos_q, pos_d;

  logic        out_valid_q;
  spg_result_t res_q, res_d;

  logic        out_free;
  logic        advance;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_RST;
      intensity_q <= INTENSITY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SWEEP_MODE:      mode_q      <= cfg_data_i[1:0];
        REG_SWEEP_INTENSITY: intensity_q <= cfg_data_i;
        default:             mode_q      <= mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req_q   <= s_axis_tuser;
      in_angle_q <= s_axis_tdata[7:0];
      in_en_q    <= s_axis_tdata[8];
    end
  end

  spg_step #(
    .PATTERN_LEN (PATTERN_LEN)
  ) u_step (
    .cur_i       (state_q),
    .pos_i       (pos_q),
    .mode_i      (mode_q),
    .intensity_i (intensity_q),
    .req_i       (in_req_q),
    .angle_i     (in_angle_q),
    .en_i        (in_en_q),
    .nxt_o       (state_d),
    .pos_o       (pos_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RST;
      pos_q   <= '0;
    end else if (advance) begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, res_q.moved, res_q.rejected, res_q.stop_active,
                          res_q.sweep_active, res_q.servo_angle};

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the servo pattern generator
// Drives ticks and commands through the input stream and predicts every result
// transfer. A directed table covers reset, the angle limits, emergency stop and
// sweep restarts. Randomised phases follow, one per mode and intensity setting,
// mostly sweep runs of ticks mixed with commands and noise. Idle gaps on both
// sides vary by phase, and two long output stalls fill the pipeline.
// ----------------------------------------------------------------------------
module tb;
  import spg_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int POS_LEN      = PATTERN_LEN_DEF;
  localparam int DRAIN_CYCLES = 6;
  localparam int STALL_CYCLES = 60;
  localparam int PHASE_ITEMS  = 148;
  localparam int NUM_PHASES   = 9;

  localparam logic [7:0] RADAR_TAB [8] = '{8'd25, 8'd55, 8'd90, 8'd125,
                                            8'd155, 8'd125, 8'd90, 8'd55};
  localparam logic [7:0] ALERT_TAB [8] = '{8'd70, 8'd110, 8'd75, 8'd105,
                                            8'd90, 8'd35, 8'd145, 8'd90};

  localparam logic [1:0] PHASE_MODE [NUM_PHASES] = '{MODE_BOUNCE, MODE_BOUNCE,
      MODE_RADAR, MODE_RADAR, MODE_ALERT, MODE_ALERT, MODE_SPARE, MODE_RADAR,
      MODE_BOUNCE};
  localparam logic [6:0] PHASE_LEVEL [NUM_PHASES] = '{7'd100, 7'd1, 7'd100,
      7'd1, 7'd100, 7'd127, 7'd0, 7'd64, 7'd37};

  typedef struct packed {
    logic [7:0] angle;
    logic       sweep;
    logic       stop;
    logic       rejected;
    logic       moved;
  } servo_res_t;

  typedef struct packed {
    logic [1:0] req;
    logic [7:0] ang;
    logic       en;
    logic       fixed;
    servo_res_t res;
  } step_row_t;

  localparam servo_res_t PRED = '0;

  localparam step_row_t DIRECTED [21] = '{
    '{REQ_TICK,      8'hFF, 1'b1, 1'b1, '{8'd90,  1'b0, 1'b0, 1'b0, 1'b0}},
    '{REQ_SET_ANGLE, 8'd0,  1'b1, 1'b1, '{8'd0,   1'b0, 1'b0, 1'b0, 1'b0}},
    '{REQ_SET_ANGLE, 8'd180, 1'b0, 1'b1, '{8'd180, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{REQ_SET_ANGLE, 8'd181, 1'b0, 1'b1, '{8'd180, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{REQ_SET_ANGLE, 8'd255, 1'b1, 1'b1, '{8'd180, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{REQ_SWEEP,     8'd0,  1'b1, 1'b1, '{8'd180, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{REQ_TICK,      8'd0,  1'b0, 1'b1, '{8'd180, 1'b1, 1'b0, 1'b0, 1'b1}},
    '{REQ_TICK,      8'h55, 1'b0, 1'b0, PRED},
    '{REQ_TICK,      8'hAA, 1'b1, 1'b0, PRED},
    '{REQ_ESTOP,     8'd7,  1'b1, 1'b1, '{8'd90,  1'b0, 1'b1, 1'b0, 1'b0}},
    '{REQ_SET_ANGLE, 8'd10, 1'b0, 1'b1, '{8'd90,  1'b0, 1'b1, 1'b1, 1'b0}},
    '{REQ_SWEEP,     8'd0,  1'b1, 1'b1, '{8'd90,  1'b0, 1'b1, 1'b1, 1'b0}},
    '{REQ_ESTOP,     8'd0,  1'b1, 1'b1, '{8'd90,  1'b0, 1'b1, 1'b0, 1'b0}},
    '{REQ_TICK,      8'hAA, 1'b0, 1'b1, '{8'd90,  1'b0, 1'b1, 1'b0, 1'b0}},
    '{REQ_ESTOP,     8'd0,  1'b0, 1'b1, '{8'd90,  1'b0, 1'b0, 1'b0, 1'b0}},
    '{REQ_ESTOP,     8'hFF, 1'b0, 1'b1, '{8'd90,  1'b0, 1'b0, 1'b0, 1'b0}},
    '{REQ_SWEEP,     8'd0,  1'b0, 1'b1, '{8'd90,  1'b0, 1'b0, 1'b0, 1'b0}},
    '{REQ_SWEEP,     8'd0,  1'b1, 1'b1, '{8'd90,  1'b1, 1'b0, 1'b0, 1'b0}},
    '{REQ_TICK,      8'd0,  1'b0, 1'b0, PRED},
    '{REQ_SET_ANGLE, 8'd45, 1'b0, 1'b1, '{8'd45,  1'b0, 1'b0, 1'b0, 1'b0}},
    '{REQ_TICK,      8'd0,  1'b1, 1'b0, PRED}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [6:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [7:0] angle_value, [8] enable_bit
  logic [1:0]  s_axis_tuser = '0;   // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [7:0] servo_angle, [8] sweep_active,
                                    // [9] stop_active, [10] rejected, [11] moved

  // predicted block state and register copies
  logic [1:0] cfg_mode = MODE_RST;
  logic [6:0] cfg_intensity = INTENSITY_RST;
  int         pred_angle = 90;
  bit         pred_dir_up = 1'b1;
  int         pred_pos = 0;
  int         pred_elapsed = 255;
  bit         pred_sweep = 1'b0;
  bit         pred_stop = 1'b0;

  servo_res_t pending_q[$];
  int         mismatches = 0;
  int         items_sent = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         stall_asks = 0;
  int         stall_seen = 0;
  int         stall_left = 0;

  servo_pattern_generator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int intensity_index();
    if (cfg_intensity < INTENSITY_MIN) return 0;
    if (cfg_intensity > INTENSITY_MAX) return 99;
    return int'(cfg_intensity) - 1;
  endfunction

  function automatic int move_interval();
    int k;
    k = intensity_index();
    case (cfg_mode)
      MODE_RADAR: return 120 - (k * 102) / 99;
      MODE_ALERT: return 140 - (k * 115) / 99;
      default:    return 45 - (k * 40) / 99;
    endcase
  endfunction

  function automatic servo_res_t servo_update(input logic [1:0] req,
                                              input logic [7:0] ang, input logic en);
    servo_res_t r;
    int step;
    r = '0;
    case (req)
      REQ_TICK: begin
        if (pred_elapsed < 255) pred_elapsed++;
        if (pred_sweep && pred_elapsed >= move_interval()) begin
          pred_elapsed = 0;
          r.moved = 1'b1;
          case (cfg_mode)
            MODE_RADAR: begin
              pred_angle = RADAR_TAB[pred_pos & 7];
              pred_pos = (pred_pos + 1) % POS_LEN;
            end
            MODE_ALERT: begin
              pred_angle = ALERT_TAB[pred_pos & 7];
              pred_pos = (pred_pos + 1) % POS_LEN;
            end
            default: begin
              step = 2 + (intensity_index() * 10) / 99;
              pred_angle += pred_dir_up ? step : -step;
              if (pred_angle >= 180) begin
                pred_angle = 180;
                pred_dir_up = 1'b0;
              end else if (pred_angle <= 0) begin
                pred_angle = 0;
                pred_dir_up = 1'b1;
              end
            end
          endcase
        end
      end
      REQ_SET_ANGLE: begin
        if (pred_stop || ang > ANGLE_MAX) begin
          r.rejected = 1'b1;
        end else begin
          pred_angle = int'(ang);
          pred_sweep = 1'b0;
        end
      end
      REQ_SWEEP: begin
        if (pred_stop) begin
          r.rejected = 1'b1;
        end else begin
          pred_sweep = en;
          pred_elapsed = 255;
          pred_pos = 0;
          if (en) pred_dir_up = 1'b1;
        end
      end
      REQ_ESTOP: begin
        if (pred_stop != en) begin
          pred_stop = en;
          pred_sweep = 1'b0;
          pred_angle = 90;
          pred_pos = 0;
          pred_elapsed = 255;
        end
      end
    endcase
    r.angle = 8'(pred_angle);
    r.sweep = pred_sweep;
    r.stop = pred_stop;
    return r;
  endfunction

  task automatic drive_request(input logic [1:0] req, input logic [7:0] ang,
                               input logic en, input logic fixed = 1'b0,
                               input servo_res_t fixed_res = '0);
    servo_res_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, en, ang};
    s_axis_tuser <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    want = servo_update(req, ang, en);
    pending_q.push_back(fixed ? fixed_res : want);
    items_sent++;
  endtask

  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_SWEEP_MODE) cfg_mode = val[1:0];
    else cfg_intensity = val;
  endtask

  task automatic run_traffic(input int quota);
    int first, kind, run, cap;
    logic [7:0] a;
    first = items_sent;
    while (items_sent - first < quota) begin
      kind = $urandom_range(99);
      if (kind < 50) begin
        // sweep run: release stop, (re)start sometimes, then a stream of ticks
        if (pred_stop && $urandom_range(3) != 0)
          drive_request(REQ_ESTOP, 8'($urandom), 1'b0);
        if (!pred_sweep || $urandom_range(1) == 0)
          drive_request(REQ_SWEEP, 8'($urandom), 1'b1);
        cap = 4 * move_interval() + 8;
        if (cap > 160) cap = 160;
        run = $urandom_range(cap, 1);
        if (run > first + quota - items_sent) run = first + quota - items_sent;
        if (run < 0) run = 0;
        repeat (run) drive_request(REQ_TICK, 8'($urandom), 1'($urandom));
      end else if (kind < 65) begin
        a = ($urandom_range(7) == 0) ? 8'($urandom_range(255, 181))
                                      : 8'($urandom_range(180, 0));
        drive_request(REQ_SET_ANGLE, a, 1'($urandom));
      end else if (kind < 75) begin
        drive_request(REQ_ESTOP, 8'($urandom), 1'b1);
        repeat ($urandom_range(4, 1))
          drive_request(2'($urandom), 8'($urandom), 1'($urandom));
        if ($urandom_range(3) != 0) drive_request(REQ_ESTOP, 8'($urandom), 1'b0);
      end else if (kind < 85) begin
        drive_request(REQ_SWEEP, 8'($urandom), ($urandom_range(3) == 0));
      end else begin
        drive_request(2'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_seen != stall_asks) begin
      stall_seen <= stall_asks;
      stall_left <= STALL_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    servo_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.angle = m_axis_tdata[7:0];
      got.sweep = m_axis_tdata[8];
      got.stop = m_axis_tdata[9];
      got.rejected = m_axis_tdata[10];
      got.moved = m_axis_tdata[11];
      if (pending_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result transfer: angle %0d sweep %b stop %b rej %b moved %b",
                   got.angle, got.sweep, got.stop, got.rejected, got.moved);
        mismatches++;
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          if (mismatches < 10)
            $display("mismatch: expected angle %0d sweep %b stop %b rej %b moved %b, %s",
                     want.angle, want.sweep, want.stop, want.rejected, want.moved,
                     $sformatf("got angle %0d sweep %b stop %b rej %b moved %b",
                               got.angle, got.sweep, got.stop, got.rejected, got.moved));
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    step_row_t row;
    wait (rst_ni);
    @(posedge clk_i);
    send_idle_pct = 30;
    recv_idle_pct = 75;
    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      drive_request(row.req, row.ang, row.en, row.fixed, row.res);
    end
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_pipeline();
      write_reg(REG_SWEEP_MODE, {5'd0, PHASE_MODE[p]});
      write_reg(REG_SWEEP_INTENSITY, PHASE_LEVEL[p]);
      case (p / 3)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct = 75;
        end
        1: begin
          send_idle_pct = 75;
          recv_idle_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // hold the output for a long stretch while input keeps coming
      if (p == 0 || p == 6) stall_asks++;
      run_traffic(PHASE_ITEMS);
    end
    drain_pipeline();
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
